FILE: hdl/mi3_pkg.sv
// Types, constants and helpers shared by the 3x3 matrix inverse.
// No dependencies.
package mi3_pkg;

  localparam int QBITS   = 33;   // quotient bits kept below the overflow check
  localparam int NUM_W   = 96;   // cofactor magnitude shifted up by 32
  localparam int DET_W   = 98;   // signed determinant
  localparam int DMAG_W  = 97;   // determinant magnitude
  localparam int CMP_W   = DMAG_W + QBITS;

  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic [31:0]        SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0]        SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic               third_column_ones;
  } in_t;

  typedef struct packed {
    logic signed [31:0] inv00;
    logic signed [31:0] inv01;
    logic signed [31:0] inv02;
    logic signed [31:0] inv10;
    logic signed [31:0] inv11;
    logic signed [31:0] inv12;
    logic signed [31:0] inv20;
    logic signed [31:0] inv21;
    logic signed [31:0] inv22;
    logic               singular;
  } out_t;

  // Truncated quotient magnitude to saturated Q16.16 code.
  function automatic logic [31:0] saturate(input logic neg, input logic ovf,
                                           input logic [QBITS-1:0] q);
    logic [31:0] r;
    if (neg) begin
      if (ovf || q > {1'b0, SAT_NEG}) r = SAT_NEG;
      else r = 32'(~q + 1'b1);
    end else begin
      if (ovf || q > {1'b0, SAT_POS}) r = SAT_POS;
      else r = q[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/mi3_div.sv
// Pipelined restoring divider, nine lanes sharing one determinant, plus saturation.
// Depends on mi3_pkg.
module mi3_div import mi3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  logic              singular_in,
  input  logic [DMAG_W-1:0] dmag,
  input  logic [63:0]       cmag [0:8],
  input  logic              neg [0:8],
  output logic              done,
  output out_t              result
);

  localparam int NST = QBITS + 1;

  logic              v   [1:NST];
  logic              sg  [1:NST];
  logic [DMAG_W-1:0] dd  [1:NST];
  logic [NUM_W-1:0]  rem [1:NST][0:8];
  logic [QBITS-1:0]  qq  [1:NST][0:8];
  logic              ng  [1:NST][0:8];
  logic              ov  [1:NST][0:8];

  // overflow check: quotient needs more than QBITS bits
  always_ff @(posedge clk) begin
    if (rst) v[1] <= 1'b0;
    else v[1] <= valid;
    sg[1] <= singular_in;
    dd[1] <= dmag;
    for (int j = 0; j < 9; j++) begin
      rem[1][j] <= {cmag[j], 32'b0};
      qq[1][j]  <= '0;
      ng[1][j]  <= neg[j];
      ov[1][j]  <= {{(CMP_W-NUM_W){1'b0}}, cmag[j], 32'b0} >= {dmag, {QBITS{1'b0}}};
    end
  end

  for (genvar k = 1; k < NST; k++) begin : g_bit
    localparam int B = QBITS - k;
    logic [CMP_W-1:0] dsh;
    logic             take [0:8];
    assign dsh = {{QBITS{1'b0}}, dd[k]} << B;
    always_comb begin
      for (int j = 0; j < 9; j++)
        take[j] = {{(CMP_W-NUM_W){1'b0}}, rem[k][j]} >= dsh;
    end
    always_ff @(posedge clk) begin
      if (rst) v[k+1] <= 1'b0;
      else v[k+1] <= v[k];
      sg[k+1] <= sg[k];
      dd[k+1] <= dd[k];
      for (int j = 0; j < 9; j++) begin
        rem[k+1][j] <= take[j] ? rem[k][j] - dsh[NUM_W-1:0] : rem[k][j];
        qq[k+1][j]  <= qq[k][j] | (QBITS'(take[j]) << B);
        ng[k+1][j]  <= ng[k][j];
        ov[k+1][j]  <= ov[k][j];
      end
    end
  end

  logic [31:0] e [0:8];
  always_comb begin
    for (int j = 0; j < 9; j++)
      e[j] = sg[NST] ? 32'b0 : saturate(ng[NST][j], ov[NST][j], qq[NST][j]);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v[NST];
    result.inv00    <= e[0];
    result.inv01    <= e[1];
    result.inv02    <= e[2];
    result.inv10    <= e[3];
    result.inv11    <= e[4];
    result.inv12    <= e[5];
    result.inv20    <= e[6];
    result.inv21    <= e[7];
    result.inv22    <= e[8];
    result.singular <= sg[NST];
  end

endmodule

FILE: hdl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by the adjugate, signed Q16.16, fully pipelined.
// Throughput: one matrix per cycle, busy never asserts.
// Pipeline: capture on the accepting edge, then
// 6 stages of products, cofactors and determinant, then 35 divider stages
// (overflow check, 33 quotient bits, saturation/output); done is registered at the last.
// Reset clears the stage valid bits only; the receiver cannot stall.
// Depends on mi3_pkg and mi3_div.
module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  item,
  output logic done,
  output out_t result
);

  assign busy = 1'b0;

  // stage 0: capture, columns a b c
  logic v0;
  logic signed [31:0] a0 [0:2], b0 [0:2], c0 [0:2];
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start;
    a0[0] <= item.m00; b0[0] <= item.m01;
    a0[1] <= item.m10; b0[1] <= item.m11;
    a0[2] <= item.m20; b0[2] <= item.m21;
    c0[0] <= item.third_column_ones ? ONE_Q16 : item.m02;
    c0[1] <= item.third_column_ones ? ONE_Q16 : item.m12;
    c0[2] <= item.third_column_ones ? ONE_Q16 : item.m22;
  end

  // stage 1: cofactor products
  logic signed [31:0] pf1 [0:8], pf2 [0:8], qf1 [0:8], qf2 [0:8];
  always_comb begin
    pf1[0] = b0[1]; pf2[0] = c0[2]; qf1[0] = b0[2]; qf2[0] = c0[1];
    pf1[1] = b0[2]; pf2[1] = c0[0]; qf1[1] = b0[0]; qf2[1] = c0[2];
    pf1[2] = b0[0]; pf2[2] = c0[1]; qf1[2] = b0[1]; qf2[2] = c0[0];
    pf1[3] = c0[1]; pf2[3] = a0[2]; qf1[3] = c0[2]; qf2[3] = a0[1];
    pf1[4] = c0[2]; pf2[4] = a0[0]; qf1[4] = c0[0]; qf2[4] = a0[2];
    pf1[5] = c0[0]; pf2[5] = a0[1]; qf1[5] = c0[1]; qf2[5] = a0[0];
    pf1[6] = a0[1]; pf2[6] = b0[2]; qf1[6] = a0[2]; qf2[6] = b0[1];
    pf1[7] = a0[2]; pf2[7] = b0[0]; qf1[7] = a0[0]; qf2[7] = b0[2];
    pf1[8] = a0[0]; pf2[8] = b0[1]; qf1[8] = a0[1]; qf2[8] = b0[0];
  end

  logic v1;
  logic signed [63:0] pp [0:8], qp [0:8];
  logic signed [31:0] a1 [0:2];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
    for (int i = 0; i < 9; i++) begin
      pp[i] <= pf1[i] * pf2[i];
      qp[i] <= qf1[i] * qf2[i];
    end
    a1 <= a0;
  end

  // stage 2: cofactors, exact in 65 bits
  logic v2;
  logic signed [64:0] cof2 [0:8];
  logic signed [31:0] a2 [0:2];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    for (int i = 0; i < 9; i++)
      cof2[i] <= {pp[i][63], pp[i]} - {qp[i][63], qp[i]};
    a2 <= a1;
  end

  // stage 3: a . (b x c) split into low and high partial products
  logic v3;
  logic signed [64:0] plo [0:2], phi [0:2];
  logic signed [64:0] cof3 [0:8];
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    for (int i = 0; i < 3; i++) begin
      plo[i] <= 65'(a2[i] * $signed({1'b0, cof2[i][31:0]}));
      phi[i] <= 65'(a2[i] * $signed(cof2[i][64:32]));
    end
    cof3 <= cof2;
  end

  // stage 4: recombine terms
  logic v4;
  logic signed [DET_W-1:0] term [0:2];
  logic signed [64:0] cof4 [0:8];
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    for (int i = 0; i < 3; i++)
      term[i] <= ($signed({phi[i][64], phi[i]}) <<< 32)
               + DET_W'(plo[i]);
    cof4 <= cof3;
  end

  // stage 5: determinant
  logic v5;
  logic signed [DET_W-1:0] det;
  logic signed [64:0] cof5 [0:8];
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    det  <= term[0] + term[1] + term[2];
    cof5 <= cof4;
  end

  // stage 6: signs and magnitudes for the divider
  logic              v6, sing6;
  logic [DMAG_W-1:0] dmag6;
  logic [63:0]       cmag6 [0:8];
  logic              neg6 [0:8];
  logic [DET_W-1:0]  det_abs;
  assign det_abs = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= v5;
    sing6 <= (det == '0);
    dmag6 <= det_abs[DMAG_W-1:0];
    for (int i = 0; i < 9; i++) begin
      cmag6[i] <= cof5[i][64] ? 64'(-cof5[i]) : cof5[i][63:0];
      neg6[i]  <= cof5[i][64] ^ det[DET_W-1];
    end
  end

  mi3_div u_div (
    .clk         (clk),
    .rst         (rst),
    .valid       (v6),
    .singular_in (sing6),
    .dmag        (dmag6),
    .cmag        (cmag6),
    .neg         (neg6),
    .done        (done),
    .result      (result)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for matrix_inverse_3x3: directed table then random matrices,
// each result checked against a table value or an exact adjugate/determinant predictor.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL.
module tb_top;
  import mi3_pkg::*;

  localparam int LATENCY = 41;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 1880;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  in_t  item = '0;
  out_t result;

  out_t inverse_q[$];
  int   n_errors = 0;
  int   idle_cycles = 0;

  matrix_inverse_3x3 dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  always #2 clk = ~clk;

  // Exact integer math on 200-bit signed values, truncating division.
  function automatic out_t predict_inverse(in_t m);
    logic signed [199:0] a[3], b[3], c[3], cof[9], det, num, q;
    logic signed [199:0] dmag, nmag;
    logic neg;
    out_t r;
    logic [31:0] e[9];
    a[0] = m.m00; a[1] = m.m10; a[2] = m.m20;
    b[0] = m.m01; b[1] = m.m11; b[2] = m.m21;
    c[0] = m.m02; c[1] = m.m12; c[2] = m.m22;
    if (m.third_column_ones) begin
      c[0] = ONE_Q16; c[1] = ONE_Q16; c[2] = ONE_Q16;
    end
    cof[0] = b[1]*c[2] - b[2]*c[1];
    cof[1] = b[2]*c[0] - b[0]*c[2];
    cof[2] = b[0]*c[1] - b[1]*c[0];
    cof[3] = c[1]*a[2] - c[2]*a[1];
    cof[4] = c[2]*a[0] - c[0]*a[2];
    cof[5] = c[0]*a[1] - c[1]*a[0];
    cof[6] = a[1]*b[2] - a[2]*b[1];
    cof[7] = a[2]*b[0] - a[0]*b[2];
    cof[8] = a[0]*b[1] - a[1]*b[0];
    det = a[0]*cof[0] + a[1]*cof[1] + a[2]*cof[2];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    dmag = (det < 0) ? -det : det;
    for (int i = 0; i < 9; i++) begin
      num = cof[i] <<< 32;
      nmag = (num < 0) ? -num : num;
      q = nmag / dmag;
      neg = (num < 0) != (det < 0);
      if (neg) e[i] = (q > 200'sh80000000) ? SAT_NEG : 32'(-q);
      else e[i] = (q > 200'sh7FFFFFFF) ? SAT_POS : q[31:0];
    end
    r.inv00 = e[0]; r.inv01 = e[1]; r.inv02 = e[2];
    r.inv10 = e[3]; r.inv11 = e[4]; r.inv12 = e[5];
    r.inv20 = e[6]; r.inv21 = e[7]; r.inv22 = e[8];
    return r;
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 262143)) - 131072);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      4: return 32'($signed($urandom_range(0, 16)) - 8);
      default: return 32'($signed($urandom_range(0, 65535)) - 32768) <<< 8;
    endcase
  endfunction

  function automatic in_t rand_matrix();
    in_t m;
    m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
         rand_entry(), rand_entry(), rand_entry(), rand_entry(), 1'b0};
    m.third_column_ones = ($urandom_range(0, 3) == 0);
    // occasionally make two rows equal to force a singular matrix
    if ($urandom_range(0, 15) == 0) begin
      m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
    end
    return m;
  endfunction

  // Checker and watchdog on the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          n_errors <= n_errors + 1;
        end else begin
          out_t exp_r;
          exp_r = inverse_q.pop_front();
          if (exp_r !== result) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, result);
            n_errors <= n_errors + 1;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  typedef struct {
    in_t  m;
    logic has_exp;
    out_t r;
  } stim_row_t;

  stim_row_t stim_table[$];

  task automatic send_beat(in_t m, logic has_exp, out_t r, logic idle_ok);
    while (idle_ok && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      @(negedge clk);
    end
    item <= m;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    inverse_q.push_back(has_exp ? r : predict_inverse(m));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (inverse_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    in_t m;
    out_t r;
    // identity: inverse is identity
    m = '0; m.m00 = ONE_Q16; m.m11 = ONE_Q16; m.m22 = ONE_Q16;
    r = '0; r.inv00 = ONE_Q16; r.inv11 = ONE_Q16; r.inv22 = ONE_Q16;
    stim_table.push_back('{m, 1'b1, r});
    // zero matrix: singular
    r = '0; r.singular = 1'b1;
    stim_table.push_back('{'0, 1'b1, r});
    // all ones: singular
    m = {{9{ONE_Q16}}, 1'b0};
    stim_table.push_back('{m, 1'b1, r});
    // ones column with ones column 0 too: singular
    m = '0; m.m00 = ONE_Q16; m.m10 = ONE_Q16; m.m20 = ONE_Q16;
    m.m11 = ONE_Q16; m.m22 = 32'h1234; m.third_column_ones = 1'b1;
    stim_table.push_back('{m, 1'b1, r});
    // tiny diagonal: inverse saturates positive
    m = '0; m.m00 = 1; m.m11 = 1; m.m22 = 1;
    r = '0; r.inv00 = SAT_POS; r.inv11 = SAT_POS; r.inv22 = SAT_POS;
    stim_table.push_back('{m, 1'b1, r});
    // tiny negative diagonal: saturates negative
    m = '0; m.m00 = -1; m.m11 = -1; m.m22 = -1;
    r = '0; r.inv00 = SAT_NEG; r.inv11 = SAT_NEG; r.inv22 = SAT_NEG;
    stim_table.push_back('{m, 1'b1, r});
    // extremes, predictor checked
    m = {{9{32'h7FFF_FFFF}}, 1'b0}; m.m11 = 32'h8000_0000;
    stim_table.push_back('{m, 1'b0, '0});
    m = {{9{32'h8000_0000}}, 1'b0}; m.m01 = 32'h7FFF_FFFF; m.m12 = 0;
    stim_table.push_back('{m, 1'b0, '0});
    m = '0; m.m00 = 32'h8000_0000; m.m11 = 32'h8000_0000; m.m22 = 32'h8000_0000;
    stim_table.push_back('{m, 1'b0, '0});
    m = '0; m.m00 = 32'h7FFF_FFFF; m.m11 = 32'h7FFF_FFFF; m.m22 = 32'hFFFF_FFFF;
    stim_table.push_back('{m, 1'b0, '0});
    m = {32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
         32'h3333_3333, 32'hCCCC_CCCC, 32'h0000_0001, 32'h8000_0001, 1'b1};
    stim_table.push_back('{m, 1'b0, '0});
    m = {32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0003_0000,
         32'h0, 32'hFFFF_0000, 32'h0002_0000, 32'h0, 1'b1};
    stim_table.push_back('{m, 1'b0, '0});
    m = {32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'hFFFE_0000,
         32'h0, 32'h0, 32'h0, 32'h0007_0000, 1'b0};
    stim_table.push_back('{m, 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i])
      send_beat(stim_table[i].m, stim_table[i].has_exp, stim_table[i].r, 1'b1);
    drain();

    // back-to-back stretch, then idling stretch
    for (int i = 0; i < N_RANDOM; i++) begin
      send_beat(rand_matrix(), 1'b0, '0, i >= 300);
      if (i == 1000) drain();
    end
    drain();
    repeat (LATENCY + 10) @(negedge clk);

    if (n_errors == 0 && inverse_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/mi3_pkg.sv
hdl/mi3_div.sv
hdl/matrix_inverse_3x3.sv
dv/tb_top.sv
